FILE: rtl/vertical_byte_framebuffer_plotter_core_macros.svh
// Assertion shorthands shared by the RTL.
// Every property is sampled on clk and switched off while rst_n is low.
`ifndef VERTICAL_BYTE_FRAMEBUFFER_PLOTTER_CORE_MACROS_SVH
`define VERTICAL_BYTE_FRAMEBUFFER_PLOTTER_CORE_MACROS_SVH

// The condition implies the expression in the same cycle.
`define VBFP_ASSERT_IMPL(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// The condition implies the expression in the next cycle.
`define VBFP_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

FILE: rtl/vbfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vbfp_pkg;

    // Action codes
    localparam logic [1:0] ACT_PIXEL = 2'd0;
    localparam logic [1:0] ACT_RUN   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // Run step directions
    localparam logic [1:0] DIR_X_INC = 2'd0;
    localparam logic [1:0] DIR_Y_INC = 2'd1;
    localparam logic [1:0] DIR_X_DEC = 2'd2;
    localparam logic [1:0] DIR_Y_DEC = 2'd3;

    // Register indexes on the configuration port
    localparam logic REG_PAGE_TOP    = 1'b0;
    localparam logic REG_PAGE_BOTTOM = 1'b1;

    localparam logic [5:0] PAGE_TOP_RESET    = 6'd0;
    localparam logic [5:0] PAGE_BOTTOM_RESET = 6'd63;

    // A single pixel runs as a one-bit pattern
    localparam logic [7:0] PIXEL_PATTERN = 8'h80;

    // Width of byte index arithmetic, wide enough for 32 pages of 256 columns
    localparam int IDX_W = 16;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] x;
        logic [7:0] y;
        logic       color;
        logic [7:0] pattern;
        logic [1:0] direction;
        logic [9:0] address;
    } in_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] pixels_written;
    } out_word_t;

endpackage

`default_nettype wire

FILE: rtl/vbfp_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vbfp_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/vbfp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module vbfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/vertical_byte_framebuffer_plotter_core.sv
// Plotter for a 1-bit COLUMNS x ROWS image kept in vertical byte pages
// (byte (y/8)*COLUMNS+x, bit y mod 8) in one single-port-write,
// registered-read RAM. One word is taken at a time; cmd.ready is low while
// it is worked. A single pixel runs as a one-bit pattern. A run checks its
// pattern bits in turn from the top, stepping past one that is clear or
// clipped; for each pixel written it reads the RAM byte and then writes it
// back, and it ends once no set bit is left, going to its result. A read
// fetches the addressed byte and then gives its result.
// Clear, and the pass that follows reset, write zero to one byte per cycle
// across the whole store of COLUMNS*ROWS/8 bytes (1024 at the default
// size) before the next word is taken, a clear then giving its result;
// configuration writes are taken throughout. A result waits in an output
// register so the next word may enter while it is unread; the block holds
// in its result state only while that register is still full and unread.
`timescale 1ns / 1ps
`default_nettype none
`include "vertical_byte_framebuffer_plotter_core_macros.svh"

module vertical_byte_framebuffer_plotter_core #(
    parameter int COLUMNS = 128,
    parameter int ROWS    = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    vbfp_stream_if.sink      cmd,
    vbfp_stream_if.source    rsp
);

    localparam int STORE_BYTES = COLUMNS * ROWS / 8;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int IW          = vbfp_pkg::IDX_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [5:0] page_top_reg;
    logic [5:0] page_bottom_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_top_reg    <= vbfp_pkg::PAGE_TOP_RESET;
            page_bottom_reg <= vbfp_pkg::PAGE_BOTTOM_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                vbfp_pkg::REG_PAGE_TOP:    page_top_reg    <= pwdata[5:0];
                vbfp_pkg::REG_PAGE_BOTTOM: page_bottom_reg <= pwdata[5:0];
                default:                   page_top_reg    <= page_top_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            vbfp_pkg::REG_PAGE_TOP:    prdata = {26'd0, page_top_reg};
            vbfp_pkg::REG_PAGE_BOTTOM: prdata = {26'd0, page_bottom_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    logic [2:0]    state_reg,     state_next;
    logic [AW-1:0] clr_addr_reg,  clr_addr_next;
    logic          clr_reply_reg, clr_reply_next;
    logic          rsp_valid_reg;

    logic [7:0]    x_reg,       x_next;
    logic [7:0]    y_reg,       y_next;
    logic          color_reg,   color_next;
    logic [7:0]    pattern_reg, pattern_next;
    logic [1:0]    dir_reg,     dir_next;
    logic [3:0]    count_reg,   count_next;
    logic [7:0]    data_reg,    data_next;
    logic          hit_reg,     hit_next;
    logic [AW-1:0] idx_reg,     idx_next;
    logic [7:0]    mask_reg,    mask_next;
    vbfp_pkg::out_word_t rsp_data_reg;

    // RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    vbfp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Shared clip, index and step unit, working on the current point
    // ------------------------------------------------------------------
    logic [7:0]    bottom_cap;
    logic [IW-1:0] plot_idx;
    logic [IW-1:0] read_addr;
    logic          plot_hit;
    logic          read_hit;
    logic [7:0]    x_step;
    logic [7:0]    y_step;
    logic          rsp_free;

    always_comb
    begin
        if ({2'd0, page_bottom_reg} > 8'(ROWS - 1))
        begin
            bottom_cap = 8'(ROWS - 1);
        end
        else
        begin
            bottom_cap = {2'd0, page_bottom_reg};
        end
    end

    assign plot_idx  = IW'(y_reg[7:3]) * IW'(COLUMNS) + IW'(x_reg);
    assign plot_hit  = (y_reg >= {2'd0, page_top_reg}) && (y_reg <= bottom_cap)
                    && ({1'b0, x_reg} < 9'(COLUMNS)) && (plot_idx < IW'(STORE_BYTES));
    assign read_addr = IW'(cmd.data.address);
    assign read_hit  = read_addr < IW'(STORE_BYTES);

    always_comb
    begin
        x_step = x_reg;
        y_step = y_reg;
        case (dir_reg)
            vbfp_pkg::DIR_X_INC: x_step = x_reg + 8'd1;
            vbfp_pkg::DIR_Y_INC: y_step = y_reg + 8'd1;
            vbfp_pkg::DIR_X_DEC: x_step = x_reg - 8'd1;
            vbfp_pkg::DIR_Y_DEC: y_step = y_reg - 8'd1;
            default:             x_step = x_reg;
        endcase
    end

    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        clr_reply_next = clr_reply_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        color_next     = color_reg;
        pattern_next   = pattern_reg;
        dir_next       = dir_reg;
        count_next     = count_reg;
        data_next      = data_reg;
        hit_next       = hit_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        ram_we         = 1'b0;
        ram_waddr      = clr_addr_reg;
        ram_wdata      = 8'd0;
        ram_raddr      = read_addr[AW-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(STORE_BYTES - 1))
                begin
                    clr_reply_next = 1'b0;
                    state_next     = clr_reply_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    x_next     = cmd.data.x;
                    y_next     = cmd.data.y;
                    color_next = cmd.data.color;
                    dir_next   = cmd.data.direction;
                    count_next = 4'd0;
                    data_next  = 8'd0;
                    case (cmd.data.action)
                        vbfp_pkg::ACT_PIXEL:
                        begin
                            pattern_next = vbfp_pkg::PIXEL_PATTERN;
                            state_next   = ST_RUN;
                        end
                        vbfp_pkg::ACT_RUN:
                        begin
                            pattern_next = cmd.data.pattern;
                            state_next   = ST_RUN;
                        end
                        vbfp_pkg::ACT_CLEAR:
                        begin
                            clr_addr_next  = '0;
                            clr_reply_next = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        vbfp_pkg::ACT_READ:
                        begin
                            hit_next   = read_hit;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                ram_raddr = plot_idx[AW-1:0];
                if (pattern_reg == 8'd0)
                begin
                    state_next = ST_DONE;
                end
                else if (pattern_reg[7] && plot_hit)
                begin
                    // fetch the byte; modify and step on the next cycle
                    idx_next   = plot_idx[AW-1:0];
                    mask_next  = 8'd1 << y_reg[2:0];
                    state_next = ST_WRITE;
                end
                else
                begin
                    x_next       = x_step;
                    y_next       = y_step;
                    pattern_next = {pattern_reg[6:0], 1'b0};
                end
            end
            ST_WRITE:
            begin
                ram_we       = 1'b1;
                ram_waddr    = idx_reg;
                ram_wdata    = color_reg ? (ram_rdata | mask_reg) : (ram_rdata & ~mask_reg);
                count_next   = count_reg + 4'd1;
                x_next       = x_step;
                y_next       = y_step;
                pattern_next = {pattern_reg[6:0], 1'b0};
                state_next   = ST_RUN;
            end
            ST_READ:
            begin
                data_next  = hit_reg ? ram_rdata : 8'd0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            clr_reply_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_reply_reg <= clr_reply_next;
            if (state_reg == ST_DONE && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        color_reg   <= color_next;
        pattern_reg <= pattern_next;
        dir_reg     <= dir_next;
        count_reg   <= count_next;
        data_reg    <= data_next;
        hit_reg     <= hit_next;
        idx_reg     <= idx_next;
        mask_reg    <= mask_next;
        if (state_reg == ST_DONE && rsp_free)
        begin
            rsp_data_reg.read_data      <= data_reg;
            rsp_data_reg.pixels_written <= count_reg;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `VBFP_ASSERT_NEXT(a_busy_after_accept, cmd.valid && cmd.ready, !cmd.ready, "word accepted while busy")
    `VBFP_ASSERT_IMPL(a_write_after_fetch, state_reg == ST_WRITE, $past(state_reg) == ST_RUN, "store write without fetch")
    `VBFP_ASSERT_IMPL(a_count_bound, rsp.valid, rsp.data.pixels_written <= 4'd8, "pixel count above eight")
    `VBFP_ASSERT_NEXT(a_clear_sweeps, cmd.valid && cmd.ready && cmd.data.action == vbfp_pkg::ACT_CLEAR, state_reg == ST_CLEAR && clr_addr_reg == '0, "clear did not start sweep")

endmodule

`default_nettype wire
